// ===== src/resolution_peak_merger_top_macros.svh =====
// Assertion macros for the peak merger.
`ifndef RESOLUTION_PEAK_MERGER_TOP_MACROS_SVH
`define RESOLUTION_PEAK_MERGER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RPM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rpm check failed");
`define RPM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rpm check failed");
`else
`define RPM_ASSERT_IMP(label, clk, rst_n, a, c)
`define RPM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/rpm_pkg.sv =====
`timescale 1ns / 1ps
package rpm_pkg;
    localparam int MzW = 32;
    localparam int IntW = 32;
    localparam int RpW = 20;
    localparam int ModeW = 2;
    localparam logic [RpW-1:0] RpReset = 20'd60000;
    localparam logic [ModeW-1:0] ModeReset = 2'd2;
    localparam logic [31:0] IntSatMax = 32'h7FFF_FFFF;
    localparam logic [23:0] Mode1Scale = 24'd13107200;
    localparam int QDepth = 2;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SQRT  = 2'd1,
        MODE_CONST = 2'd2,
        MODE_INV   = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        REG_RP   = 1'b0,
        REG_MODE = 1'b1
    } t_reg;

    // item handed from front to back
    typedef struct packed {
        logic [MzW-1:0]  mz;
        logic [IntW-1:0] inten;
        logic            last;
        logic            elig;  // sign checks of new item passed
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GAP, ST_G2, ST_M2, ST_CMP1, ST_CMPW, ST_CMP3, ST_NUM,
        ST_DIV, ST_EMIT, ST_FLUSH
    } t_state;
endpackage

// ===== src/rpm_front.sv =====
`timescale 1ns / 1ps
module rpm_front #(
    parameter int Depth = rpm_pkg::QDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rpm_pkg::MzW-1:0]       i_mz,
    input  logic [rpm_pkg::IntW-1:0]      i_inten,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rpm_pkg::t_item                o_item
);
    import rpm_pkg::*;
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_item r_q [Depth];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [AW:0] r_cnt, n_cnt;
    logic push, pop;
    t_item w_item;

    assign o_ready = (r_cnt != (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rp];

    always_comb begin
        w_item.mz = i_mz;
        w_item.inten = i_inten;
        w_item.last = i_last;
        w_item.elig = !i_mz[MzW-1] && (i_mz != '0) && !i_inten[IntW-1] && (i_inten != '0);
        n_wp = r_wp;
        n_rp = r_rp;
        if (push) n_wp = (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
        if (pop) n_rp = (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
        n_cnt = r_cnt + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_q[r_wp] <= w_item;
    end
endmodule

// ===== src/rpm_div.sv =====
`timescale 1ns / 1ps
module rpm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    import rpm_pkg::*;
    // restoring divider, one bit a cycle while busy; quotient truncated to 32 bits
    logic [63:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0] r_cnt;
    logic r_busy;
    logic [33:0] w_sh;
    logic [34:0] w_diff;

    assign w_sh = {r_rem[32:0], r_q[63]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};
    assign o_quo = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[34]) begin
                r_rem <= w_diff[33:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/rpm_back.sv =====
`timescale 1ns / 1ps
module rpm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [rpm_pkg::RpW-1:0]  i_rp,
    input  logic [rpm_pkg::ModeW-1:0] i_mode,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rpm_pkg::t_item           i_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [rpm_pkg::MzW-1:0]  o_mz,
    output logic [rpm_pkg::IntW-1:0] o_inten,
    output logic                     o_end,
    output logic                     o_open
);
    import rpm_pkg::*;

    t_state r_st, n_st;
    t_item r_it;
    logic r_ov;
    logic [31:0] r_omz, r_oin;
    logic [31:0] r_gap;
    logic [51:0] r_g;
    logic [127:0] r_acc;   // mode-1 products, built up in the ST_CMP1 and ST_CMPW steps
    logic [127:0] r_rhs;
    logic [63:0] r_m2;
    logic [63:0] r_num;
    logic r_ok;
    logic r_oval;
    logic [31:0] r_xmz, r_xin;
    logic r_xend;
    logic [1:0] r_step;

    logic div_start, div_done;
    logic [31:0] div_q;
    logic [32:0] w_sum;
    logic [31:0] w_gapd;

    assign w_sum = {1'b0, r_oin} + {1'b0, r_it.inten};
    assign w_gapd = r_it.mz - r_omz;
    assign o_ready = (r_st == ST_IDLE) && !r_oval;
    assign o_valid = r_oval;
    assign o_mz = r_xmz;
    assign o_inten = r_xin;
    assign o_end = r_xend;
    assign o_open = r_ov;

    rpm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  (w_sum),
        .o_done (div_done),
        .o_quo  (div_q)
    );

    logic w_try;
    assign w_try = r_ov && r_it.elig && !r_omz[31] && (r_omz != '0) &&
                   !r_oin[31] && (r_oin != '0);

    // width compare per mode; with r_ok set, a non-positive gap or zero R merges
    logic w_cmp, w_merge;
    assign w_cmp = (i_mode == MODE_CONST && 64'(r_g) <= 64'(r_it.mz)) ||
                   (i_mode == MODE_INV && 64'(r_g) * 64'd200 <= (r_m2 >> 16)) ||
                   (i_mode == MODE_SQRT && r_acc <= r_rhs);
    assign w_merge = r_ok && (r_gap[31] || r_gap == '0 || i_rp == '0 || w_cmp);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (i_valid && o_ready) n_st = ST_GAP;
            ST_GAP:   n_st = ST_G2;
            ST_G2:    n_st = ST_M2;
            ST_M2:    n_st = ST_CMP1;
            ST_CMP1:  if (r_step == 2'd3) n_st = ST_CMPW;
            ST_CMPW:  n_st = ST_CMP3;
            ST_CMP3:  n_st = w_merge ? ST_NUM : ST_EMIT;
            ST_NUM:   if (r_step == 2'd2) n_st = ST_DIV;
            ST_DIV:   if (div_done) n_st = ST_FLUSH;
            ST_EMIT:  if (!r_oval) n_st = ST_FLUSH;
            ST_FLUSH: if (!r_oval) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign div_start = (r_st == ST_NUM) && (r_step == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_oval <= 1'b0;
            r_omz <= '0;
            r_oin <= '0;
            r_step <= '0;
            r_ok <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    r_step <= '0;
                    if (i_valid && o_ready) r_it <= i_item;
                end
                ST_GAP: begin
                    r_gap <= w_gapd;
                    r_ok <= w_try && (i_mode != MODE_NONE);
                end
                ST_G2: begin
                    r_g <= 52'(r_gap) * 52'(i_rp);
                    r_m2 <= 64'(r_it.mz) * 64'(r_it.mz);
                end
                ST_M2: begin
                    r_step <= '0;
                    // (gap*R)^2 * scale in 26-bit slices of g, mz^3 from 32-bit halves of mz^2
                    r_acc <= '0;
                    r_rhs <= '0;
                end
                ST_CMP1: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        2'd0: r_acc <= 128'(r_g[51:26] * r_g[51:26]) << 52;
                        2'd1: r_acc <= r_acc + (128'(r_g[51:26] * r_g[25:0]) << 27);
                        2'd2: r_acc <= r_acc + 128'(r_g[25:0] * r_g[25:0]);
                        default: r_rhs <= 128'(r_m2[63:32] * r_it.mz) << 32;
                    endcase
                end
                ST_CMPW: begin
                    // times 200 * 2^16, by shifts
                    r_acc <= ((r_acc << 7) + (r_acc << 6) + (r_acc << 3)) << 16;
                    r_rhs <= r_rhs + 128'(r_m2[31:0] * r_it.mz);
                end
                ST_CMP3: begin
                    r_step <= '0;
                end
                ST_NUM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd0) r_num <= 64'(r_omz) * 64'(r_oin);
                    else if (r_step == 2'd1)
                        r_num <= r_num + 64'(r_it.mz) * 64'(r_it.inten);
                end
                ST_DIV: if (div_done) begin
                    r_omz <= div_q;
                    r_oin <= w_sum[32] || w_sum[31] ? IntSatMax : w_sum[31:0];
                end
                ST_EMIT: if (!r_oval) begin
                    if (r_ov) begin
                        r_oval <= 1'b1;
                        r_xmz <= r_omz;
                        r_xin <= r_oin;
                        r_xend <= 1'b0;
                    end
                    r_ov <= 1'b1;
                    r_omz <= r_it.mz;
                    r_oin <= r_it.inten;
                end
                ST_FLUSH: if (!r_oval && r_it.last) begin
                    r_oval <= 1'b1;
                    r_xmz <= r_omz;
                    r_xin <= r_oin;
                    r_xend <= 1'b1;
                    r_ov <= 1'b0;
                    r_omz <= '0;
                    r_oin <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== src/resolution_peak_merger_top.sv =====
`timescale 1ns / 1ps
// An accepted input word passes the gap, product and width-compare steps before
// it is emitted; a merge adds the weighted sum and the bit-serial divider instead.
// The back end takes one peak at a time and accepts no new peak until it is done
// with the last; the width-compare sequencer, the divider and the receiver hold it.
// A 2-word queue decouples the input side.
// Reset (i_rst_n low, synchronous): no open peak, R = 60000, mode 2.
module resolution_peak_merger_top #(
    parameter int QDepth = rpm_pkg::QDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // peak_mz[31:0], peak_intensity[63:32]
    input  logic        s_axis_tlast,   // final_peak
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // merged_mz[31:0], merged_int[63:32]
    output logic        m_axis_tlast,   // spectrum_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rpm_pkg::*;
`include "resolution_peak_merger_top_macros.svh"

    logic [RpW-1:0] r_rp;
    logic [ModeW-1:0] r_mode;
    logic q_valid, q_ready, w_open;
    t_item q_item;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    // register index from word address
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MODE) prdata = 32'(r_mode);
        else prdata = 32'(r_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= RpReset;
            r_mode <= ModeReset;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_RP) r_rp <= pwdata[RpW-1:0];
            else r_mode <= pwdata[ModeW-1:0];
        end
    end

    rpm_front #(.Depth(QDepth)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_mz   (s_axis_tdata[31:0]),
        .i_inten(s_axis_tdata[63:32]),
        .i_last (s_axis_tlast),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_item (q_item)
    );

    rpm_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rp   (r_rp),
        .i_mode (r_mode),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_item (q_item),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_mz   (m_axis_tdata[31:0]),
        .o_inten(m_axis_tdata[63:32]),
        .o_end  (m_axis_tlast),
        .o_open (w_open)
    );

    // a flushed word leaves no open peak behind
    `RPM_ASSERT_NXT(a_flush_closes, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, !w_open)
    // output word holds while stalled
    `RPM_ASSERT_NXT(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ===== dv/tb_resolution_peak_merger_top.sv =====
`timescale 1ns / 1ps
// Peak merger testbench: directed spectra for the special cases, then random
// spectra under several resolution settings and back-pressure patterns.
module tb_resolution_peak_merger_top;
    import rpm_pkg::*;

    localparam int StallLimit = 20000;  // cycles with no word accepted
    localparam int SettleCycles = 200;  // covers the slowest merge
    localparam int LongHold = 2000;

    typedef struct {
        logic [31:0] mz;
        logic [31:0] inten;
        logic        fin;
    } t_peak;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // peak_mz[31:0], peak_intensity[63:32]
    logic        s_axis_tlast = 1'b0; // final_peak
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // merged_mz[31:0], merged_int[63:32]
    logic        m_axis_tlast;        // spectrum_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    resolution_peak_merger_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: mirrors registers and the open peak
    logic [RpW-1:0] res_power = RpReset;
    t_mode          mode = t_mode'(ModeReset);
    logic           open_vld = 1'b0;
    logic [31:0]    open_mz = '0;
    logic [31:0]    open_int = '0;

    t_peak merged_q[$];
    int    n_err = 0;
    int    n_peaks_in = 0;
    int    n_peaks_out = 0;
    int    n_merges = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    hold_cnt = 0;
    bit    hold_go = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h got %h (t=%0t)", what, want, got, $time);
        n_err++;
    endtask

    // gap <= resolution width at the new m/z, exact on the raw Q16.16 values
    function automatic bit within_width(input longint cur, input longint nxt);
        logic [63:0]  g, m;
        logic [127:0] lhs, rhs;
        if (mode == MODE_NONE) return 1'b0;
        if (nxt - cur <= 0) return 1'b1;
        m = nxt;
        g = (nxt - cur) * longint'(res_power);
        case (mode)
            MODE_CONST: return g <= m;
            MODE_INV:   return g * 200 <= ((m * m) >> 16);
            default: begin
                // square both sides: g^2 * 200 * 2^16 <= m^3
                lhs = 128'(g) * 128'(g) * 128'(Mode1Scale);
                rhs = 128'(m) * 128'(m) * 128'(m);
                return lhs <= rhs;
            end
        endcase
    endfunction

    task automatic predict_merge(input logic [31:0] nmz, input logic [31:0] nin,
                                 input logic fin);
        longint cm, ci, xm, xi;
        logic [63:0] sum, num;
        bit merged;
        t_peak p;
        merged = 1'b0;
        if (open_vld) begin
            cm = $signed(open_mz);
            ci = $signed(open_int);
            xm = $signed(nmz);
            xi = $signed(nin);
            if (cm > 0 && xm > 0 && ci > 0 && xi > 0 && within_width(cm, xm)) begin
                sum = ci + xi;
                num = cm * ci + xm * xi;
                open_mz = 32'(num / sum);
                open_int = (sum > 64'(IntSatMax)) ? IntSatMax : sum[31:0];
                merged = 1'b1;
                n_merges++;
            end
            if (!merged) begin
                p = '{open_mz, open_int, 1'b0};
                merged_q.push_back(p);
                open_mz = nmz;
                open_int = nin;
            end
        end else begin
            open_vld = 1'b1;
            open_mz = nmz;
            open_int = nin;
        end
        if (fin) begin
            p = '{open_mz, open_int, 1'b1};
            merged_q.push_back(p);
            open_vld = 1'b0;
            open_mz = '0;
            open_int = '0;
        end
    endtask

    // one peak word; valid stays high into the next call unless it idles
    task automatic send_peak(input logic [31:0] mz, input logic [31:0] inten,
                             input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {inten, mz};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_merge(mz, inten, fin);
        n_peaks_in++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (merged_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);  // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RP) res_power = val[RpW-1:0];
        else mode = t_mode'(val[ModeW-1:0]);
    endtask

    task automatic set_resolution(input t_mode md, input logic [RpW-1:0] rp);
        wait_drained();
        apb_write(REG_MODE, 32'(md));
        apb_write(REG_RP, 32'(rp));
    endtask

    // mostly sorted spectrum with gaps near the expected width; some words are noise
    task automatic send_spectrum(input int len, input int noise_pct);
        longint mz0, mz, w, nxt;
        logic [31:0] inten;
        mz0 = longint'($urandom_range(60, 450)) << 16;
        mz0 += $urandom_range(65535);
        mz = mz0;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) inten = $urandom_range(32'h4000_0000, IntSatMax);
            else inten = $urandom_range(1, 1000000);
            if ($urandom_range(99) < noise_pct)
                send_peak($urandom, $urandom, k == len - 1);
            else
                send_peak(32'(mz), inten, k == len - 1);
            w = mz / longint'(res_power == 0 ? 1 : res_power);
            if (w > 64'h100_0000) w = 64'h100_0000;
            nxt = mz + ($urandom_range(7) == 0 ? longint'($urandom_range(1 << 22))
                                                : longint'($urandom_range(0, 2 * w + 2)));
            mz = (nxt > 64'h7FFF_FFFF) ? mz0 : nxt;  // wrap gives an out-of-order peak
        end
    endtask

    // results: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_peak want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            n_peaks_out++;
            if (merged_q.size() == 0) begin
                report_mismatch("unexpected word", 32'h0, m_axis_tdata[31:0]);
            end else begin
                want = merged_q.pop_front();
                if (m_axis_tdata[31:0] !== want.mz)
                    report_mismatch("merged_mz", want.mz, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== want.inten)
                    report_mismatch("merged_int", want.inten, m_axis_tdata[63:32]);
                if (m_axis_tlast !== want.fin)
                    report_mismatch("spectrum_end", 32'(want.fin), 32'(m_axis_tlast));
            end
        end
        m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_cnt = LongHold;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
        end
    end

    // watchdog: no word moving on either side for too long
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= StallLimit) begin
            $display("timeout: %0d cycles without traffic", quiet);
            $display("tb_resolution_peak_merger_top: done, errors");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        // defaults: mode 2, R 60000; 200 m/z width is 218 raw units
        send_peak(32'h00C8_0000, 32'd1000, 1'b0);
        send_peak(32'h00C8_00DA, 32'd3000, 1'b0);  // gap = width: merges
        send_peak(32'h00C8_01B6, 32'd5, 1'b0);     // gap just over: emits
        send_peak(32'h00C8_0100, 32'd7, 1'b1);     // negative gap merges, then flush
    endtask

    task automatic test_special_cases();
        set_resolution(MODE_CONST, 20'd60000);
        send_peak(32'h0064_0000, 32'd10, 1'b1);          // lone final peak
        send_peak(32'h0064_0000, 32'h7FFF_FFFF, 1'b0);   // saturating sum
        send_peak(32'h0064_0001, 32'h7FFF_FFFF, 1'b0);
        send_peak(32'h0064_0002, 32'd0, 1'b0);           // zero intensity: no merge
        send_peak(32'h0064_0003, 32'hFFFF_FFFF, 1'b0);   // negative intensity
        send_peak(32'h8000_0000, 32'd5, 1'b0);           // most negative m/z
        send_peak(32'h0000_0000, 32'd5, 1'b0);           // zero m/z
        send_peak(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);   // extremes
        send_peak(32'h7FFF_FFFF, 32'd1, 1'b0);
        send_peak(32'h7FFF_FFFF, 32'd1, 1'b1);
        set_resolution(MODE_CONST, 20'd0);               // zero R: width unbounded
        send_peak(32'h0010_0000, 32'd2, 1'b0);
        send_peak(32'h2000_0000, 32'd6, 1'b1);
        set_resolution(MODE_NONE, 20'd60000);            // no mode: never merges
        send_peak(32'h0064_0000, 32'd2, 1'b0);
        send_peak(32'h0064_0000, 32'd6, 1'b1);
        set_resolution(MODE_SQRT, 20'd1);
        send_peak(32'h0001_0000, 32'd3, 1'b0);
        send_peak(32'h0001_0000, 32'd9, 1'b0);
        send_peak(32'h7FFF_FFFF, 32'd9, 1'b1);
        set_resolution(MODE_INV, 20'd1048575);
        send_peak(32'h03E8_0000, 32'd4, 1'b0);
        send_peak(32'h03E8_0001, 32'd4, 1'b0);
        send_peak(32'h03E8_0002, 32'd4, 1'b0);
        send_peak(32'h03E8_1000, 32'd4, 1'b1);
    endtask

    task automatic random_phase(input int n_items, input int tx_pct, input int rx_pct,
                                input bit with_pressure);
        int goal;
        t_mode md;
        logic [RpW-1:0] rp;
        goal = n_peaks_in + n_items;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (with_pressure) begin
            // receiver holds off while mostly unmergeable words keep coming
            hold_go = 1'b1;
            send_spectrum(12, 100);
            wait_drained();
        end
        while (n_peaks_in < goal) begin
            if ($urandom_range(5) == 0) begin
                md = t_mode'($urandom_range(1, 3));
                case ($urandom_range(3))
                    0: rp = 20'd1;
                    1: rp = 20'hFFFFF;
                    2: rp = 20'd60000;
                    default: rp = $urandom_range(1000, 300000);
                endcase
                set_resolution(md, rp);
            end
            if (with_pressure && $urandom_range(15) == 0) begin
                hold_go = 1'b1;
                send_spectrum(12, 0);
                wait_drained();  // sender pauses until every result is back
            end
            send_spectrum($urandom_range(1, 12), 10);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        random_phase(380, 18, 59, 1'b0);
        random_phase(380, 59, 18, 1'b0);
        random_phase(390, 0, 0, 1'b1);
        wait_drained();
        $display("covered %0d peaks in, %0d merged peaks out, %0d merges",
                 n_peaks_in, n_peaks_out, n_merges);
        $display("modes 1..3, R from 1 to 1048575, stalls and a long output hold-off");
        if (n_err == 0 && merged_q.size() == 0) begin
            $display("tb_resolution_peak_merger_top: done, clean");
        end else begin
            $display("%0d mismatches, %0d results still expected", n_err, merged_q.size());
            $display("tb_resolution_peak_merger_top: done, errors");
        end
        $finish;
    end
endmodule
